// ----- hw/rtl/epas_pkg.sv -----
`timescale 1ns / 1ps
package epas_pkg;

  localparam int CORDIC_ITERS = 16;
  localparam int ITER_W       = 4;

  // cordic start value, gain * 2^30
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] CFG_ANGLE_LOW  = 2'd0;
  localparam logic [1:0] CFG_ANGLE_HIGH = 2'd1;
  localparam logic [1:0] CFG_ANGLE_STEP = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TRIG,
    ST_COST,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [15:0] cos_q15;
    logic signed [15:0] sin_q15;
  } trig_t;

  typedef struct packed {
    logic signed [32:0] ax;
    logic signed [32:0] ay;
    logic signed [32:0] bx;
    logic signed [32:0] by;
  } vec_t;

  // arctangent of 2^-i, hundredths of a degree times 2^16
  function automatic logic signed [31:0] atan_lut(input logic [ITER_W-1:0] i);
    logic signed [31:0] v;
    case (i)
      4'd0:    v = 32'sd294912000;
      4'd1:    v = 32'sd174096719;
      4'd2:    v = 32'sd91987925;
      4'd3:    v = 32'sd46694507;
      4'd4:    v = 32'sd23437865;
      4'd5:    v = 32'sd11730358;
      4'd6:    v = 32'sd5866610;
      4'd7:    v = 32'sd2933484;
      4'd8:    v = 32'sd1466764;
      4'd9:    v = 32'sd733385;
      4'd10:   v = 32'sd366693;
      4'd11:   v = 32'sd183346;
      4'd12:   v = 32'sd91673;
      4'd13:   v = 32'sd45837;
      4'd14:   v = 32'sd22918;
      4'd15:   v = 32'sd11459;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] clamp_q15(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) r = 16'sh7fff;
    else if (v < -20'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- hw/rtl/epas_in_if.sv -----
`timescale 1ns / 1ps
interface epas_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ref_start_x;
  logic signed [31:0] ref_start_y;
  logic signed [31:0] ref_end_x;
  logic signed [31:0] ref_end_y;
  logic signed [31:0] meas_start_x;
  logic signed [31:0] meas_start_y;
  logic signed [31:0] meas_end_x;
  logic signed [31:0] meas_end_y;

  modport source (output valid, ref_start_x, ref_start_y, ref_end_x, ref_end_y,
                  meas_start_x, meas_start_y, meas_end_x, meas_end_y, input ready);
  modport sink (input valid, ref_start_x, ref_start_y, ref_end_x, ref_end_y,
                meas_start_x, meas_start_y, meas_end_x, meas_end_y, output ready);
endinterface

// ----- hw/rtl/epas_out_if.sv -----
`timescale 1ns / 1ps
interface epas_out_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] shift_x;
  logic signed [32:0] shift_y;
  logic signed [15:0] best_angle;
  logic [63:0]        best_cost;
  logic [1:0]         search_status;

  modport source (output valid, shift_x, shift_y, best_angle, best_cost, search_status,
                  input ready);
  modport sink (input valid, shift_x, shift_y, best_angle, best_cost, search_status,
                output ready);
endinterface

// ----- hw/rtl/endpoint_pose_alignment_search.sv -----
`timescale 1ns / 1ps
// endpoint pose alignment search
// in_ch carries the reference and measured segment endpoints (Q16.16); a transfer
// takes place when valid and ready are both high. out_ch returns one result per
// item: the midpoint shift, the best candidate angle, its cost and a status code.
// cfg_we/cfg_addr/cfg_wdata write angle_low, angle_high and angle_step; write them
// only while no item is in flight.
// the block handles one item at a time and drops in_ch.ready until the result has
// been taken. each candidate angle runs a 16-step cordic and then a ten-phase
// cost sequence on one shared multiplier; an item runs its N candidates one after
// another (N at most MAX_ANGLES).
// the result sits in output registers with out_ch.valid high until the receiver
// takes it; a stalled receiver only holds the block in that state.
// reset (rst_n low, synchronous) returns the sequencer to idle and restores the
// register defaults of -10.00, +10.00 and 0.10 degrees.
module endpoint_pose_alignment_search
  import epas_pkg::*;
#(
  parameter int MAX_ANGLES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  epas_in_if.sink     in_ch,
  epas_out_if.source  out_ch
);

  localparam int KW = $clog2(MAX_ANGLES + 1);

  // configuration registers
  logic signed [15:0] angle_low_r, angle_high_r;
  logic [15:0]        angle_step_r;

  state_t             state_r, state_nxt;

  // per-item working registers
  vec_t               vec_r;
  logic signed [32:0] shift_x_r, shift_y_r;
  logic signed [17:0] ang_r;
  logic [KW-1:0]      cnt_r;
  logic signed [15:0] best_angle_r;
  logic [63:0]        best_cost_r;
  logic [1:0]         status_r;

  logic               in_xfer;
  logic               past_high;
  logic               at_limit;
  logic               cordic_start, cordic_done;
  logic               cost_go, cost_done;
  trig_t              trig;
  logic [63:0]        cost;
  logic signed [33:0] sum_x, sum_y;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign past_high = ang_r > 18'(angle_high_r);
  assign at_limit  = cnt_r == KW'(MAX_ANGLES);

  // midpoint difference, doubled
  assign sum_x = 34'(in_ch.ref_start_x) + 34'(in_ch.ref_end_x)
               - 34'(in_ch.meas_start_x) - 34'(in_ch.meas_end_x);
  assign sum_y = 34'(in_ch.ref_start_y) + 34'(in_ch.ref_end_y)
               - 34'(in_ch.meas_start_y) - 34'(in_ch.meas_end_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_low_r  <= -16'sd1000;
      angle_high_r <= 16'sd1000;
      angle_step_r <= 16'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ANGLE_LOW:  angle_low_r  <= cfg_wdata;
        CFG_ANGLE_HIGH: angle_high_r <= cfg_wdata;
        CFG_ANGLE_STEP: angle_step_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer: check candidate, run cordic, run cost, update best
  always_comb begin
    state_nxt    = state_r;
    cordic_start = 1'b0;
    cost_go      = 1'b0;
    case (state_r)
      ST_IDLE:  if (in_xfer) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (at_limit || past_high) begin
          state_nxt = ST_OUT;
        end else begin
          cordic_start = 1'b1;
          state_nxt    = ST_TRIG;
        end
      end
      ST_TRIG: begin
        if (cordic_done) begin
          cost_go   = 1'b1;
          state_nxt = ST_COST;
        end
      end
      ST_COST:  if (cost_done) state_nxt = ST_CHECK;
      ST_OUT:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_xfer) begin
      vec_r.ax     <= 33'(in_ch.ref_start_x) - 33'(in_ch.ref_end_x);
      vec_r.ay     <= 33'(in_ch.ref_start_y) - 33'(in_ch.ref_end_y);
      vec_r.bx     <= 33'(in_ch.meas_start_x) - 33'(in_ch.meas_end_x);
      vec_r.by     <= 33'(in_ch.meas_start_y) - 33'(in_ch.meas_end_y);
      shift_x_r    <= sum_x[33:1];
      shift_y_r    <= sum_y[33:1];
      ang_r        <= 18'(angle_low_r);
      cnt_r        <= '0;
      best_angle_r <= '0;
      best_cost_r  <= '0;
    end
    if (state_r == ST_CHECK && (at_limit || past_high)) begin
      // an empty range wins over the limit, as no candidate ran
      if (cnt_r == '0) status_r <= STATUS_EMPTY;
      else if (at_limit && !past_high) status_r <= STATUS_TRUNC;
      else status_r <= STATUS_OK;
    end
    if (state_r == ST_COST && cost_done) begin
      // first minimum wins: strict compare
      if (cnt_r == '0 || cost < best_cost_r) begin
        best_cost_r  <= cost;
        best_angle_r <= ang_r[15:0];
      end
      ang_r <= ang_r + 18'(angle_step_r);
      cnt_r <= cnt_r + KW'(1);
    end
  end

  epas_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (ang_r[15:0]),
    .done  (cordic_done),
    .trig  (trig)
  );

  epas_cost u_cost (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cost_go),
    .trig  (trig),
    .vec   (vec_r),
    .done  (cost_done),
    .cost  (cost)
  );

  assign in_ch.ready          = state_r == ST_IDLE;
  assign out_ch.valid         = state_r == ST_OUT;
  assign out_ch.shift_x       = shift_x_r;
  assign out_ch.shift_y       = shift_y_r;
  assign out_ch.best_angle    = best_angle_r;
  assign out_ch.best_cost     = best_cost_r;
  assign out_ch.search_status = status_r;

endmodule

// ----- hw/rtl/epas_cordic.sv -----
`timescale 1ns / 1ps
module epas_cordic
  import epas_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] angle,
  output logic               done,
  output trig_t              trig
);

  logic                    busy_r, busy_nxt;
  logic                    fin_r, fin_nxt;
  logic [ITER_W-1:0]       it_r;
  logic signed [33:0]      x_r, y_r;
  logic signed [31:0]      z_r;
  logic                    neg_r;
  logic                    done_r;
  trig_t                   trig_r;

  logic signed [17:0]      a_wrap, a_fold;
  logic                    fold;
  logic signed [33:0]      xs, ys;
  logic signed [18:0]      cq, sq;
  logic signed [19:0]      cn, sn;

  // wrap into (-180, 180] degrees, then fold into [-90, 90]
  always_comb begin
    a_wrap = 18'(angle);
    if (a_wrap > 18'sd18000) a_wrap = a_wrap - 18'sd36000;
    else if (a_wrap <= -18'sd18000) a_wrap = a_wrap + 18'sd36000;
    fold   = 1'b0;
    a_fold = a_wrap;
    if (a_wrap > 18'sd9000) begin
      a_fold = a_wrap - 18'sd18000;
      fold   = 1'b1;
    end else if (a_wrap < -18'sd9000) begin
      a_fold = a_wrap + 18'sd18000;
      fold   = 1'b1;
    end
  end

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  // round Q2.30 to Q1.15
  always_comb begin
    logic signed [33:0] xr, yr;
    xr = x_r + 34'sd16384;
    yr = y_r + 34'sd16384;
    cq = xr[33:15];
    sq = yr[33:15];
    cn = neg_r ? -20'(cq) : 20'(cq);
    sn = neg_r ? -20'(sq) : 20'(sq);
  end

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && it_r == ITER_W'(CORDIC_ITERS - 1)) begin
      busy_nxt = 1'b0;
      fin_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= fin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_GAIN;
      y_r   <= '0;
      z_r   <= {a_fold[15:0], 16'h0000};
      neg_r <= fold;
      it_r  <= '0;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_lut(it_r);
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_lut(it_r);
      end
      it_r <= it_r + ITER_W'(1);
    end
    if (fin_r) begin
      trig_r.cos_q15 <= clamp_q15(cn);
      trig_r.sin_q15 <= clamp_q15(sn);
    end
  end

  assign done = done_r;
  assign trig = trig_r;

endmodule

// ----- hw/rtl/epas_cost.sv -----
`timescale 1ns / 1ps
module epas_cost
  import epas_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  trig_t       trig,
  input  vec_t        vec,
  output logic        done,
  output logic [63:0] cost
);

  localparam logic [3:0] PH_LAST = 4'd9;

  logic               busy_r;
  logic [3:0]         ph_r;
  logic               done_r;
  logic signed [33:0] ma, mb;
  logic signed [67:0] full;
  logic signed [65:0] prod_r;
  logic signed [66:0] acc_r;
  logic signed [66:0] prod_x;
  logic signed [66:0] rsum;
  logic signed [36:0] dx_r, dy_r;
  logic [36:0]        ux_r, uy_r;
  logic [31:0]        hx, hy;
  logic               lx, ly, ovf;
  logic [63:0]        cost_r;

  assign hx     = ux_r[32:1];
  assign lx     = ux_r[0];
  assign hy     = uy_r[32:1];
  assign ly     = uy_r[0];
  assign ovf    = (ux_r[36:33] != 4'd0) || (uy_r[36:33] != 4'd0);
  assign prod_x = {prod_r[65], prod_r};

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (ph_r)
      4'd0: begin ma = 34'(trig.cos_q15); mb = 34'(vec.bx); end
      4'd1: begin ma = 34'(trig.sin_q15); mb = 34'(vec.by); end
      4'd2: begin ma = 34'(trig.sin_q15); mb = 34'(vec.bx); end
      4'd3: begin ma = 34'(trig.cos_q15); mb = 34'(vec.by); end
      4'd6: begin ma = {2'b00, hx}; mb = {2'b00, hx}; end
      4'd7: begin ma = {2'b00, hy}; mb = {2'b00, hy}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign full = ma * mb;

  // rotated component rounding: second product is subtracted for x, added for y
  always_comb begin
    if (ph_r == 4'd2) rsum = acc_r - prod_x + 67'sd16384;
    else rsum = acc_r + prod_x + 67'sd16384;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= '0;
      end else if (busy_r) begin
        if (ph_r == PH_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          ph_r   <= '0;
        end else begin
          ph_r <= ph_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= full[65:0];
    if (busy_r) begin
      case (ph_r)
        4'd1: acc_r <= prod_x;
        4'd2: dx_r  <= 37'(vec.ax) - 37'($signed(rsum[50:15]));
        4'd3: acc_r <= prod_x;
        4'd4: dy_r  <= 37'(vec.ay) - 37'($signed(rsum[50:15]));
        4'd5: begin
          ux_r <= dx_r[36] ? 37'(-dx_r) : 37'(dx_r);
          uy_r <= dy_r[36] ? 37'(-dy_r) : 37'(dy_r);
        end
        4'd7: acc_r <= prod_x + (lx ? 67'(hx) : 67'sd0);
        4'd8: acc_r <= acc_r + prod_x + (ly ? 67'(hy) : 67'sd0);
        4'd9: begin
          if (ovf || acc_r[66:63] != 4'd0) cost_r <= '1;
          else cost_r <= {acc_r[62:0], lx & ly};
        end
        default: ;
      endcase
    end
  end

  assign done = done_r;
  assign cost = cost_r;

endmodule
